FILE: design/mepr_pkg.sv
// ----------------------------------------------------------------------------
// mepr_pkg
// Shared widths, codes, constants and types of the echo pulse ranger.
// ----------------------------------------------------------------------------
package mepr_pkg;

  localparam int NUM_CHANNELS_DEF = 10;

  localparam int FUNC_W  = 2;
  localparam int ECHO_W  = 10;
  localparam int TIME_W  = 32;
  localparam int CH_W    = 4;
  localparam int DIST_W  = 15;
  localparam int TEMP_W  = 8;

  // speed of sound term in units of 1e-3 m/s, 331300 + 606 * temp
  localparam int SPEED_W = 19;
  localparam int SPEED_EXT_W = SPEED_W + 1;
  localparam logic [SPEED_W-1:0] SPEED_BASE  = 19'd331300;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 19'd343420;
  localparam int SPEED_COEF = 606;

  // width * speed / 2000000, with 2000000 = 2^7 * 15625
  localparam int PROD_W      = TIME_W + SPEED_W;
  localparam int DIV_SHIFT   = 7;
  localparam int Q1_W        = 29;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 43;
  localparam int PROD2_W     = Q1_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M   = 30'd562949954;
  localparam logic [PROD_W-1:0]  SAT_LIMIT = 51'd65536000000;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 15'd32767;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_REPORT = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef struct packed {
    logic              arm;
    logic              sample;
    logic [TIME_W-1:0] time_us;
  } lane_cmd_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] width;
  } lane_status_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DIST_W-1:0] distance_mm;
    logic              valid_res;
    logic              last;
  } out_item_t;

endpackage

FILE: design/mepr_in_if.sv
// ----------------------------------------------------------------------------
// mepr_in_if
// Command item channel: function code, echo levels and timestamp.
// ----------------------------------------------------------------------------
interface mepr_in_if;
  import mepr_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ECHO_W-1:0] echo_levels;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output func, output echo_levels, output time_us,
                  input ready);
  modport sink   (input valid, input func, input echo_levels, input time_us,
                  output ready);
endinterface

FILE: design/mepr_out_if.sv
// ----------------------------------------------------------------------------
// mepr_out_if
// Result item channel: one distance per channel of a report.
// ----------------------------------------------------------------------------
interface mepr_out_if;
  import mepr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [DIST_W-1:0] distance_mm;
  logic              valid_res;
  logic              last;

  modport source (output valid, output channel, output distance_mm,
                  output valid_res, output last, input ready);
  modport sink   (input valid, input channel, input distance_mm,
                  input valid_res, input last, output ready);
endinterface

FILE: design/mepr_lane.sv
// ----------------------------------------------------------------------------
// mepr_lane
// One echo channel: edge tracking and pulse width capture.
// ----------------------------------------------------------------------------
module mepr_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mepr_pkg::lane_cmd_t   cmd_i,
  input  logic                  level_i,
  output mepr_pkg::lane_status_t status_o
);
  import mepr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] time_q, time_d;

  always_comb begin
    phase_d = phase_q;
    time_d  = time_q;
    if (cmd_i.arm) begin
      phase_d = PH_WAIT;
      time_d  = '0;
    end else if (cmd_i.sample) begin
      case (phase_q)
        PH_WAIT: begin
          if (level_i) begin
            phase_d = PH_HIGH;
            time_d  = cmd_i.time_us;
          end
        end
        PH_HIGH: begin
          if (!level_i) begin
            phase_d = PH_DONE;
            time_d  = cmd_i.time_us - time_q;  // wraps modulo 2^32
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  assign status_o.done  = (phase_q == PH_DONE);
  assign status_o.width = time_q;

endmodule

FILE: design/mepr_report.sv
// ----------------------------------------------------------------------------
// mepr_report
// Walks the lanes one per cycle while the output is not stalled and converts widths to distances.
// ----------------------------------------------------------------------------
module mepr_report #(
  parameter int NUM_CHANNELS = mepr_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [mepr_pkg::TEMP_W-1:0]                 cfg_wdata_i,
  input  logic                                        start_i,
  input  mepr_pkg::lane_status_t [NUM_CHANNELS-1:0]   lanes_i,
  output logic                                        busy_o,
  output mepr_pkg::out_item_t                         out_o,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i
);
  import mepr_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  logic [SPEED_W-1:0]     speed_q;
  logic signed [SPEED_EXT_W-1:0] temp_ext, speed_sum;

  logic                   busy_q;
  logic [CH_W-1:0]        ch_q;
  logic                   adv;
  lane_status_t           sel;

  logic                   s1_valid_q, s1_ok_q, s1_last_q;
  logic [CH_W-1:0]        s1_ch_q;
  logic [PROD_W-1:0]      s1_prod_q;

  logic                   s2_valid_q, s2_ok_q, s2_last_q, s2_sat_q;
  logic [CH_W-1:0]        s2_ch_q;
  logic [PROD2_W-1:0]     s2_prod_q;

  logic                   out_valid_q;
  out_item_t              out_q;
  logic [DIST_W-1:0]      dist_val;

  // speed term recomputed on each temperature write
  assign temp_ext  = SPEED_EXT_W'(signed'(cfg_wdata_i));
  assign speed_sum = signed'({1'b0, SPEED_BASE})
                   + temp_ext * SPEED_EXT_W'(SPEED_COEF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
    end else if (cfg_we_i) begin
      speed_q <= speed_sum[SPEED_W-1:0];
    end
  end

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch_q == CH_W'(i)) sel = lanes_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ch_q        <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        ch_q   <= '0;
      end else if (busy_q && adv) begin
        if (ch_q == LAST_CH) begin
          busy_q <= 1'b0;
        end
        ch_q <= ch_q + CH_W'(1);
      end
      if (adv) begin
        s1_valid_q  <= busy_q;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // stage 1: width times speed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ok_q   <= sel.done;
      s1_ch_q   <= ch_q;
      s1_last_q <= (ch_q == LAST_CH);
      s1_prod_q <= PROD_W'(sel.width) * PROD_W'(speed_q);
    end
  end

  // stage 2: drop 2^7, multiply by reciprocal of 15625
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ok_q   <= s1_ok_q;
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
      s2_sat_q  <= (s1_prod_q >= SAT_LIMIT);
      s2_prod_q <= PROD2_W'(s1_prod_q[DIV_SHIFT +: Q1_W]) * PROD2_W'(RECIP_M);
    end
  end

  always_comb begin
    if (!s2_ok_q) begin
      dist_val = '0;
    end else if (s2_sat_q) begin
      dist_val = DIST_MAX;
    end else begin
      dist_val = s2_prod_q[RECIP_SHIFT +: DIST_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.channel     <= s2_ch_q;
      out_q.distance_mm <= dist_val;
      out_q.valid_res   <= s2_ok_q;
      out_q.last        <= s2_last_q;
    end
  end

  assign busy_o      = busy_q;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("report start did not raise busy");

  a_ch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ch_q <= LAST_CH))
    else $error("channel walk ran past last lane");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.valid_res) |-> (out_q.distance_mm == '0))
    else $error("incomplete pulse reported a nonzero distance");

  a_ch_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !out_q.last) |=>
      (!out_valid_q || out_q.channel == $past(out_q.channel) + CH_W'(1)))
    else $error("result channels out of order");

  a_last_ch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.channel == LAST_CH))
    else $error("last flag on wrong channel");

endmodule

FILE: design/multi_echo_pulse_ranger.sv
// ----------------------------------------------------------------------------
// multi_echo_pulse_ranger
// Multi-channel ultrasonic echo pulse width capture and distance conversion.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    func, echo_levels, time_us
//  out_i     out  valid / ready    channel, distance_mm, valid_res, last
//  cfg       in   cfg_we_i only    cfg_wdata_i = air_temp_celsius
//
//  arm and sample items are accepted back to back
//  a report item walks the lanes one per cycle through a shared
//  three-stage multiply pipeline, holding off input until the walk ends,
//  with one result per cycle while the output is not stalled;
//  an output stall freezes the whole report pipeline in place
//  async active-low reset: lanes idle, temperature 20 C
// ----------------------------------------------------------------------------
module multi_echo_pulse_ranger #(
  parameter int NUM_CHANNELS = mepr_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mepr_pkg::TEMP_W-1:0] cfg_wdata_i,
  mepr_in_if.sink                     in_i,
  mepr_out_if.source                  out_i
);
  import mepr_pkg::*;

  logic                             in_fire;
  logic                             busy;
  lane_cmd_t                        cmd;
  lane_status_t [NUM_CHANNELS-1:0]  lanes;
  out_item_t                        res;

  // a new item is taken whenever no report is still walking the lanes
  assign in_i.ready = !busy;
  assign in_fire    = in_i.valid && !busy;

  // one command broadcast to every lane
  assign cmd.arm     = in_fire && (in_i.func == FUNC_ARM);
  assign cmd.sample  = in_fire && (in_i.func == FUNC_SAMPLE);
  assign cmd.time_us = in_i.time_us;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    logic level;
    // channels without an echo bit always see a low line
    if (c < ECHO_W) begin : g_wired
      assign level = in_i.echo_levels[c];
    end else begin : g_unwired
      assign level = 1'b0;
    end

    mepr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .level_i  (level),
      .status_o (lanes[c])
    );
  end

  // merging stage: serial readout and width to distance conversion
  mepr_report #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_report (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (in_fire && (in_i.func == FUNC_REPORT)),
    .lanes_i     (lanes),
    .busy_o      (busy),
    .out_o       (res),
    .out_valid_o (out_i.valid),
    .out_ready_i (out_i.ready)
  );

  assign out_i.channel     = res.channel;
  assign out_i.distance_mm = res.distance_mm;
  assign out_i.valid_res   = res.valid_res;
  assign out_i.last        = res.last;

endmodule
